@@ hw/rtl/bra_pkg.sv @@
package bra_pkg;

	localparam int MAP_SECTORS = 4096;
	localparam int MAP_BYTES   = (MAP_SECTORS + 7) / 8;
	localparam int SEC_W       = $clog2(MAP_SECTORS);
	localparam int BA_W        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

	localparam int TYPE_W = 2;
	localparam int POS_W  = 12;
	localparam int STOP_W = 13;
	localparam int LEN_W  = 13;
	localparam int BYTE_W = 8;

	// scan index: one bit above the map so it can step to -1 or to MAP_SECTORS
	localparam int IDX_W = (SEC_W + 1 > STOP_W) ? SEC_W + 1 : STOP_W;

	localparam int TAIL_BITS = MAP_SECTORS % 8;
	localparam logic [BYTE_W-1:0] LAST_MASK =
		(TAIL_BITS == 0) ? 8'hFF : BYTE_W'(8'hFF << (8 - TAIL_BITS));

	typedef enum logic [TYPE_W-1:0] {
		REQ_LOAD   = 2'd0,
		REQ_MARK   = 2'd1,
		REQ_SEARCH = 2'd2,
		REQ_READ   = 2'd3
	} req_kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_LOAD,
		ST_SCAN,
		ST_MODIFY,
		ST_WRITE,
		ST_POST
	} state_t;

	typedef struct packed {
		logic              found;
		logic [POS_W-1:0]  run_index;
		logic [BYTE_W-1:0] read_byte;
	} rsp_t;

	typedef struct packed {
		logic push;
		rsp_t data;
	} res_t;

endpackage

@@ hw/rtl/bra_if.sv @@
interface bra_req_if;
	logic                         valid;
	logic                         ready;
	logic [bra_pkg::TYPE_W-1:0]   req_type;
	logic [bra_pkg::POS_W-1:0]    position;
	logic [bra_pkg::STOP_W-1:0]   stop_index;
	logic [bra_pkg::LEN_W-1:0]    run_length;
	logic                         scan_down;
	logic                         claim;
	logic [bra_pkg::BYTE_W-1:0]   load_byte;

	modport source (
		output valid, req_type, position, stop_index, run_length, scan_down, claim,
		       load_byte,
		input  ready
	);
	modport sink (
		input  valid, req_type, position, stop_index, run_length, scan_down, claim,
		       load_byte,
		output ready
	);
endinterface

interface bra_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        found;
	logic [bra_pkg::POS_W-1:0]   run_index;
	logic [bra_pkg::BYTE_W-1:0]  read_byte;

	modport source (
		output valid, found, run_index, read_byte,
		input  ready
	);
	modport sink (
		input  valid, found, run_index, read_byte,
		output ready
	);
endinterface

@@ hw/rtl/bitmap_run_allocator.sv @@
// Channel | Dir | Payload                                              | Transfer
// req     | in  | req_type position stop_index run_length scan_down     | valid & ready
//         |     | claim load_byte                                      |
// rsp     | out | found run_index read_byte                            | valid & ready
//
// One item at a time. Load writes its byte from IDLE; read fetches one map byte. Search
// fetches each map byte it reaches and scans it in a shift register, one bit per cycle,
// pausing to fetch the next byte. Claim adds a fetch, modify and write per map byte the run touches.
// After reset a clearing pass writes all MAP_BYTES (512) map bytes, one per cycle,
// with req.ready low. A result waits in the output register; the next request is
// taken meanwhile and stalls only if its own result is ready before rsp frees.
module bitmap_run_allocator (
	input  logic       clk,
	input  logic       arst_n,
	bra_req_if.sink    req,
	bra_rsp_if.source  rsp
);

	bra_pkg::res_t res;
	bra_pkg::rsp_t rsp_q;
	logic          rsp_valid_q;
	logic          out_free;

	assign out_free = !rsp_valid_q || rsp.ready;

	bra_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.out_free (out_free),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res.push) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.push) rsp_q <= res.data;
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.found     = rsp_q.found;
	assign rsp.run_index = rsp_q.run_index;
	assign rsp.read_byte = rsp_q.read_byte;

endmodule

@@ hw/rtl/bra_ram.sv @@
module bra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/bra_seq.sv @@
module bra_seq (
	input  logic              clk,
	input  logic              arst_n,
	bra_req_if.sink           req,
	input  logic              out_free,
	output bra_pkg::res_t     res
);

	localparam int IW = bra_pkg::IDX_W;
	localparam int AW = bra_pkg::BA_W;
	localparam int BW = bra_pkg::BYTE_W;
	localparam int LW = bra_pkg::LEN_W;

	bra_pkg::state_t    st_q, st_d;
	bra_pkg::req_kind_t op_q;
	logic               mod_q;
	logic [AW-1:0]      clr_q;

	logic [bra_pkg::POS_W-1:0]  pos_q;
	logic [bra_pkg::STOP_W-1:0] stop_q;
	logic [LW-1:0]              len_q;
	logic                       down_q;
	logic                       claim_q;
	logic [IW-1:0]              i_q;
	logic [IW-1:0]              first_q;
	logic [IW-1:0]              total_q;
	logic [LW-1:0]              rem_q;
	logic [BW-1:0]              sr_q;
	logic [2:0]                 bit_q;
	logic [AW-1:0]              wb_q;
	bra_pkg::rsp_t              res_q;

	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [BW-1:0] wr_data, rd_data;

	logic               accept;
	bra_pkg::req_kind_t in_kind;
	logic               in_byte_ok, in_sec_ok, in_last;
	logic               run_ok, scan_bit, hit, byte_cross, run_found, set_now;
	logic [IW-1:0]      i_step;

	bra_ram #(.WIDTH(BW), .DEPTH(bra_pkg::MAP_BYTES)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign in_kind    = bra_pkg::req_kind_t'(req.req_type);
	assign accept     = req.valid && req.ready;
	assign in_byte_ok = IW'(req.position) < IW'(bra_pkg::MAP_BYTES);
	assign in_sec_ok  = IW'(req.position) < IW'(bra_pkg::MAP_SECTORS);
	assign in_last    = IW'(req.position) == IW'(bra_pkg::MAP_BYTES - 1);

	assign run_ok     = (i_q < IW'(bra_pkg::MAP_SECTORS)) && (i_q != IW'(stop_q));
	assign scan_bit   = down_q ? sr_q[0] : sr_q[BW-1];
	assign i_step     = down_q ? i_q - IW'(1) : i_q + IW'(1);
	assign hit        = !scan_bit && (total_q + IW'(1) == IW'(len_q));
	assign byte_cross = down_q ? (i_q[2:0] == 3'd0) : (i_q[2:0] == 3'd7);
	assign run_found  = first_q != '0;
	assign set_now    = (bit_q == i_q[2:0]) && (rem_q != '0);

	always_comb begin
		st_d = st_q;
		case (st_q)
			bra_pkg::ST_CLEAR: begin
				if (clr_q == AW'(bra_pkg::MAP_BYTES - 1)) st_d = bra_pkg::ST_IDLE;
			end
			bra_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_kind)
						bra_pkg::REQ_LOAD:   st_d = bra_pkg::ST_POST;
						bra_pkg::REQ_MARK:   st_d = in_sec_ok ? bra_pkg::ST_FETCH
						                                      : bra_pkg::ST_POST;
						bra_pkg::REQ_SEARCH: st_d = bra_pkg::ST_FETCH;
						bra_pkg::REQ_READ:   st_d = in_byte_ok ? bra_pkg::ST_FETCH
						                                       : bra_pkg::ST_POST;
						default:             st_d = bra_pkg::ST_POST;
					endcase
				end
			end
			bra_pkg::ST_FETCH: st_d = bra_pkg::ST_LOAD;
			bra_pkg::ST_LOAD: begin
				if (mod_q) st_d = bra_pkg::ST_MODIFY;
				else if (op_q == bra_pkg::REQ_READ) st_d = bra_pkg::ST_POST;
				else st_d = bra_pkg::ST_SCAN;
			end
			bra_pkg::ST_SCAN: begin
				if (!run_ok) st_d = bra_pkg::ST_POST;
				else if (hit) st_d = (run_found && claim_q) ? bra_pkg::ST_FETCH
				                                            : bra_pkg::ST_POST;
				else if (byte_cross) st_d = bra_pkg::ST_FETCH;
			end
			bra_pkg::ST_MODIFY: begin
				if (bit_q == 3'd7) st_d = bra_pkg::ST_WRITE;
			end
			bra_pkg::ST_WRITE: st_d = (rem_q != '0) ? bra_pkg::ST_FETCH : bra_pkg::ST_POST;
			bra_pkg::ST_POST: begin
				if (out_free) st_d = bra_pkg::ST_IDLE;
			end
			default: st_d = bra_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = st_q == bra_pkg::ST_IDLE;
		rd_en     = st_q == bra_pkg::ST_FETCH;
		rd_addr   = (op_q == bra_pkg::REQ_READ && !mod_q) ? AW'(pos_q) : AW'(i_q >> 3);
		wr_en     = 1'b0;
		wr_addr   = wb_q;
		wr_data   = sr_q;
		res.push  = 1'b0;
		res.data  = res_q;
		case (st_q)
			bra_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			bra_pkg::ST_IDLE: begin
				wr_en   = accept && in_kind == bra_pkg::REQ_LOAD && in_byte_ok;
				wr_addr = AW'(req.position);
				wr_data = in_last ? (req.load_byte & bra_pkg::LAST_MASK) : req.load_byte;
			end
			bra_pkg::ST_WRITE: wr_en = 1'b1;
			bra_pkg::ST_POST:  res.push = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= bra_pkg::ST_CLEAR;
			clr_q <= '0;
			mod_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == bra_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (st_q == bra_pkg::ST_IDLE && accept) begin
				mod_q <= in_kind == bra_pkg::REQ_MARK;
			end else if (st_q == bra_pkg::ST_SCAN && run_ok && hit) begin
				mod_q <= run_found && claim_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			bra_pkg::ST_IDLE: begin
				if (accept) begin
					op_q    <= in_kind;
					pos_q   <= req.position;
					stop_q  <= req.stop_index;
					len_q   <= req.run_length;
					down_q  <= req.scan_down;
					claim_q <= req.claim;
					i_q     <= IW'(req.position);
					first_q <= IW'(req.position);
					total_q <= '0;
					rem_q   <= LW'(1);
					res_q   <= '0;
				end
			end
			bra_pkg::ST_FETCH: wb_q <= rd_addr;
			bra_pkg::ST_LOAD: begin
				bit_q <= '0;
				if (mod_q) begin
					sr_q <= rd_data;
				end else if (op_q == bra_pkg::REQ_READ) begin
					res_q.read_byte <= (pos_q == bra_pkg::POS_W'(bra_pkg::MAP_BYTES - 1))
						? (rd_data & bra_pkg::LAST_MASK) : rd_data;
				end else begin
					// align the current sector to the end the scan consumes from
					sr_q <= down_q ? (rd_data >> (3'd7 - i_q[2:0])) : (rd_data << i_q[2:0]);
				end
			end
			bra_pkg::ST_SCAN: begin
				if (run_ok) begin
					sr_q <= down_q ? (sr_q >> 1) : (sr_q << 1);
					// claim walks upward from the low end of the run
					i_q  <= !hit ? i_step : (down_q ? i_q : first_q);
					if (scan_bit) begin
						total_q <= '0;
						first_q <= i_step;
					end else begin
						total_q <= total_q + IW'(1);
					end
					if (hit) begin
						res_q.found     <= run_found;
						res_q.run_index <= bra_pkg::POS_W'(first_q);
						rem_q           <= len_q;
					end
				end
			end
			bra_pkg::ST_MODIFY: begin
				sr_q  <= {sr_q[BW-2:0], sr_q[BW-1] | set_now};
				bit_q <= bit_q + 3'd1;
				if (set_now) begin
					i_q   <= i_q + IW'(1);
					rem_q <= rem_q - LW'(1);
				end
			end
			default: ;
		endcase
	end

endmodule

@@ hw/rtl/bra_checker.sv @@
module bra_rsp_props (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         found,
	input logic [bra_pkg::POS_W-1:0]    run_index,
	input logic [bra_pkg::BYTE_W-1:0]   read_byte
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("rsp valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(found) && $stable(run_index)
		&& $stable(read_byte))
		else $error("rsp payload changed while stalled");

	a_found_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> run_index != '0)
		else $error("found run reported at index zero");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> read_byte == '0)
		else $error("search result carries read data");

endmodule

bind bitmap_run_allocator bra_rsp_props u_bra_rsp_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.found     (rsp.found),
	.run_index (rsp.run_index),
	.read_byte (rsp.read_byte)
);

@@ bench/bra_checker.sv @@
`timescale 1ns / 100ps

module bra_checker (
	input  logic clk,
	input  logic arst_n,
	bra_req_if   req,
	bra_rsp_if   rsp,
	output int   mismatches,
	output int   owed,
	output int   answered,
	output int   searches,
	output int   runs_found
);
	import bra_pkg::*;

	bit   sector_used [MAP_SECTORS];
	rsp_t owed_rsp [$];

	task automatic report_mismatch(string msg);
		$display("%0t ns  mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// walk from start toward stop; downward runs report their highest sector
	function automatic int find_free_run(int start, int stop, int len, bit down);
		int stride;
		int i;
		int head;
		int total;
		stride = down ? -1 : 1;
		i      = start;
		head   = start;
		total  = 0;
		while (i != stop && i >= 0 && i < MAP_SECTORS) begin
			if (sector_used[i]) begin
				total = 0;
				head  = i + stride;
			end else begin
				total++;
				if (total == len)
					return head;
			end
			i += stride;
		end
		return 0;
	endfunction

	function automatic rsp_t serve_request(req_kind_t kind, int pos, int stop, int len,
					       bit down, bit take, logic [BYTE_W-1:0] lbyte);
		rsp_t res;
		int   k;
		int   s;
		int   hit;
		int   lo;
		res = '0;
		case (kind)
		REQ_LOAD: begin
			if (pos < MAP_BYTES)
				for (k = 0; k < 8; k++) begin
					s = pos * 8 + k;
					if (s < MAP_SECTORS)
						sector_used[s] = lbyte[7 - k];
				end
		end
		REQ_MARK: begin
			if (pos < MAP_SECTORS)
				sector_used[pos] = 1'b1;
		end
		REQ_SEARCH: begin
			hit = find_free_run(pos, stop, len, down);
			if (hit != 0) begin
				res.found     = 1'b1;
				res.run_index = POS_W'(hit);
				if (take) begin
					lo = down ? hit - len + 1 : hit;
					for (k = 0; k < len; k++) begin
						s = lo + k;
						if (s >= 0 && s < MAP_SECTORS)
							sector_used[s] = 1'b1;
					end
				end
			end
		end
		default: begin
			if (pos < MAP_BYTES)
				for (k = 0; k < 8; k++) begin
					s = pos * 8 + k;
					if (s < MAP_SECTORS && sector_used[s])
						res.read_byte[7 - k] = 1'b1;
				end
		end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		rsp_t got;
		if (!arst_n) begin
			foreach (sector_used[s])
				sector_used[s] = 1'b0;
			owed_rsp.delete();
			mismatches = 0;
			answered   = 0;
			searches   = 0;
			runs_found = 0;
			owed <= 0;
		end else begin
			// retire the result first: it can never belong to a request taken at this edge
			if (rsp.valid && rsp.ready) begin
				answered++;
				got.found     = rsp.found;
				got.run_index = rsp.run_index;
				got.read_byte = rsp.read_byte;
				if (owed_rsp.size() == 0) begin
					report_mismatch($sformatf("result %0d/%0d/%02h with nothing owed",
						got.found, got.run_index, got.read_byte));
				end else begin
					want = owed_rsp.pop_front();
					if (got.found !== want.found)
						report_mismatch($sformatf("found %0d, want %0d",
							got.found, want.found));
					if (got.run_index !== want.run_index)
						report_mismatch($sformatf("run_index %0d, want %0d",
							got.run_index, want.run_index));
					if (got.read_byte !== want.read_byte)
						report_mismatch($sformatf("read_byte %02h, want %02h",
							got.read_byte, want.read_byte));
				end
			end
			if (req.valid && req.ready) begin
				want = serve_request(req_kind_t'(req.req_type), int'(req.position),
					int'(req.stop_index), int'(req.run_length), req.scan_down,
					req.claim, req.load_byte);
				if (req_kind_t'(req.req_type) == REQ_SEARCH) begin
					searches++;
					if (want.found)
						runs_found++;
				end
				owed_rsp.push_back(want);
			end
			owed <= owed_rsp.size();
		end
	end

endmodule

@@ bench/tb_bitmap_run_allocator.sv @@
`timescale 1ns / 100ps

module tb_bitmap_run_allocator;
	import bra_pkg::*;

	localparam longint LIMIT_NS    = 64'd200_000_000;
	localparam int     DRAIN_LIMIT = 60000;
	localparam int     TAIL_CYCLES = 200;

	logic clk;
	logic arst_n;
	int   src_idle   = 0;
	int   sink_stall = 0;
	int   window     = 0;
	int   sent       = 0;
	int   mismatches;
	int   owed;
	int   answered;
	int   searches;
	int   runs_found;

	bra_req_if req ();
	bra_rsp_if rsp ();

	bitmap_run_allocator uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	bra_checker watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.mismatches (mismatches),
		.owed       (owed),
		.answered   (answered),
		.searches   (searches),
		.runs_found (runs_found)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= ($urandom_range(99) >= sink_stall);
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("timed out with %0d results owed", owed);
		$display("tb_bitmap_run_allocator: FAIL");
		$finish;
	end

	task automatic push_request(req_kind_t kind, int pos, int stop, int len, bit down,
				    bit take, int lbyte);
		if (src_idle > 0 && $urandom_range(99) < src_idle) begin
			req.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle);
		end
		req.valid      <= 1'b1;
		req.req_type   <= kind;
		req.position   <= POS_W'(pos);
		req.stop_index <= STOP_W'(stop);
		req.run_length <= LEN_W'(len);
		req.scan_down  <= down;
		req.claim      <= take;
		req.load_byte  <= BYTE_W'(lbyte);
		do @(posedge clk); while (!req.ready);
		sent++;
	endtask

	// hold the source until every owed result has come back or DRAIN_LIMIT runs out
	task automatic drain();
		int waited;
		waited = 0;
		req.valid <= 1'b0;
		do begin
			@(posedge clk);
			waited++;
		end while (owed != 0 && waited < DRAIN_LIMIT);
	endtask

	task automatic random_request();
		int pick;
		int start;
		int stop;
		int span;
		int len;
		int sel;
		bit down;
		if ($urandom_range(99) < 12)
			window = $urandom_range(0, MAP_BYTES - 1);
		pick = $urandom_range(99);
		if (pick < 8) begin
			push_request(req_kind_t'($urandom_range(3)), $urandom_range(4095),
				$urandom_range(8191), $urandom_range(8191), 1'($urandom_range(1)),
				1'($urandom_range(1)), $urandom_range(255));
		end else if (pick < 33) begin
			push_request(REQ_LOAD, window + $urandom_range(0, 3), 0, 0, 0, 0,
				($urandom_range(2) == 0) ? 0 : $urandom_range(255));
		end else if (pick < 45) begin
			start = window * 8 + $urandom_range(0, 31);
			push_request(REQ_MARK, (start > 4095) ? 4095 : start, 0, 0, 0, 0, 0);
		end else if (pick < 80) begin
			start = window * 8 + $urandom_range(0, 31);
			if (start > 4095)
				start = 4095;
			down = 1'($urandom_range(1));
			span = $urandom_range(0, 48);
			if (!down)
				stop = start + span;
			else if (start >= span)
				stop = start - span;
			else
				stop = $urandom_range(start + 1, 8191);
			sel = $urandom_range(99);
			if (sel < 10)
				len = 0;
			else if (sel < 80)
				len = $urandom_range(1, 10);
			else
				len = $urandom_range(8191);
			push_request(REQ_SEARCH, start, stop, len, down, 1'($urandom_range(1)), 0);
		end else begin
			push_request(REQ_READ, window + $urandom_range(0, 3), 0, 0, 0, 0, 0);
		end
	endtask

	initial begin
		int src_phase [4];
		int sink_phase [4];
		int ph;
		bit lost;
		src_phase  = '{0, 66, 0, 26};
		sink_phase = '{0, 0, 66, 26};
		lost = 1'b0;

		arst_n         <= 1'b0;
		req.valid      <= 1'b0;
		req.req_type   <= REQ_LOAD;
		req.position   <= '0;
		req.stop_index <= '0;
		req.run_length <= '0;
		req.scan_down  <= 1'b0;
		req.claim      <= 1'b0;
		req.load_byte  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		push_request(REQ_READ,   0,    0,    0,    0, 0, 0);
		// whole free map upward: the run sits at sector zero, so nothing is reported
		push_request(REQ_SEARCH, 0,    4096, 4096, 0, 1, 0);
		push_request(REQ_SEARCH, 4095, 8191, 4096, 1, 0, 0);
		push_request(REQ_SEARCH, 10,   20,   0,    0, 1, 0);
		push_request(REQ_LOAD,   511,  0,    0,    0, 0, 8'hFF);
		push_request(REQ_LOAD,   4095, 0,    0,    0, 0, 8'hA5);
		push_request(REQ_READ,   4095, 0,    0,    0, 0, 0);
		push_request(REQ_READ,   511,  0,    0,    0, 0, 0);
		push_request(REQ_MARK,   4095, 0,    0,    0, 0, 0);
		push_request(REQ_MARK,   0,    0,    0,    0, 0, 0);
		push_request(REQ_READ,   0,    0,    0,    0, 0, 0);
		push_request(REQ_LOAD,   1,    0,    0,    0, 0, 8'h81);
		push_request(REQ_LOAD,   2,    0,    0,    0, 0, 8'h00);
		push_request(REQ_SEARCH, 1,    24,   6,    0, 1, 0);
		push_request(REQ_READ,   0,    0,    0,    0, 0, 0);
		push_request(REQ_SEARCH, 23,   0,    7,    1, 1, 0);
		push_request(REQ_READ,   2,    0,    0,    0, 0, 0);
		// run past the top of the map before meeting the stop index
		push_request(REQ_SEARCH, 4090, 5000, 3,    0, 1, 0);
		push_request(REQ_SEARCH, 4095, 4095, 1,    0, 0, 0);
		push_request(REQ_SEARCH, 0,    4096, 1,    1, 1, 0);
		push_request(REQ_LOAD,   0,    0,    0,    0, 0, 8'h00);
		push_request(REQ_SEARCH, 0,    4096, 1,    1, 1, 0);
		push_request(REQ_READ,   0,    0,    0,    0, 0, 0);
		push_request(REQ_SEARCH, 10,   2,    3,    1, 1, 0);
		push_request(REQ_READ,   0,    0,    0,    0, 0, 0);
		push_request(REQ_SEARCH, 12,   40,   10,   0, 1, 0);
		push_request(REQ_READ,   3,    0,    0,    0, 0, 0);
		drain();

		for (ph = 0; ph < 4; ph++) begin
			src_idle   = src_phase[ph];
			sink_stall = sink_phase[ph];
			repeat (28) random_request();
			drain();
		end

		src_idle   = 0;
		sink_stall = 0;
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (owed != 0) begin
			$display("%0d results never arrived", owed);
			lost = 1'b1;
		end

		$display("Sent %0d requests across four idling phases (none, source, sink, both).",
			sent);
		$display("Checked %0d results; %0d run searches, %0d of them found a run.",
			answered, searches, runs_found);
		if (mismatches == 0 && !lost)
			$display("tb_bitmap_run_allocator: PASS");
		else
			$display("tb_bitmap_run_allocator: FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/bra_pkg.sv
hw/rtl/bra_if.sv
hw/rtl/bra_ram.sv
hw/rtl/bra_seq.sv
hw/rtl/bitmap_run_allocator.sv
hw/rtl/bra_checker.sv
bench/bra_checker.sv
bench/tb_bitmap_run_allocator.sv
